FILE: sv/crrm_pkg.sv
// ----------------------------------------------------------------------------
// crrm_pkg
// Shared constants, types and helpers of the chained range remap block.
// ----------------------------------------------------------------------------
package crrm_pkg;

  // Table geometry and value width
  localparam int NUM_STAGES        = 8;
  localparam int ENTRIES_PER_STAGE = 64;
  localparam int VALUE_BITS        = 40;
  localparam int TABLE_DEPTH       = NUM_STAGES * ENTRIES_PER_STAGE;
  localparam int ADDR_W            = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int STG_CNT_W         = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1;
  localparam int SLOT_CNT_W        = (ENTRIES_PER_STAGE > 1) ? $clog2(ENTRIES_PER_STAGE) : 1;

  // Input field widths
  localparam int OP_W    = 2;
  localparam int STAGE_W = 3;
  localparam int SLOT_W  = 6;

  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [ADDR_W-1:0]     addr_t;

  // Operation codes; the fourth code is ignored
  typedef enum logic [OP_W-1:0] {
    OP_WRITE     = 2'd0,
    OP_TRANSLATE = 2'd1,
    OP_RESTART   = 2'd2
  } op_e;

  // One table word
  typedef struct packed {
    logic   used;
    value_t dest;
    value_t src;
    value_t len;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Controller to datapath commands
  typedef struct packed {
    logic  clr_wr;
    addr_t clr_addr;
    logic  entry_wr;
    logic  rd_en;
    addr_t rd_addr;
    logic  rd_first;
    logic  rd_last;
    logic  load_value;
    logic  restart_min;
    logic  load_out;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;
  } dp_sts_t;

  // Flat table address of a stage and slot
  function automatic addr_t entry_addr(addr_t st, addr_t sl);
    return addr_t'(st * addr_t'(ENTRIES_PER_STAGE) + sl);
  endfunction

endpackage

FILE: sv/crrm_if.sv
// ----------------------------------------------------------------------------
// crrm_req_if / crrm_rsp_if
// Valid/ready channels of the chained range remap block.
// ----------------------------------------------------------------------------
interface crrm_req_if;
  import crrm_pkg::*;

  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  logic [STAGE_W-1:0]  stage;
  logic [SLOT_W-1:0]   slot;
  logic                entry_valid;
  value_t              dest_start;
  value_t              src_start;
  value_t              range_length;
  value_t              value;

  modport source (
    output valid, op, stage, slot, entry_valid, dest_start, src_start,
           range_length, value,
    input  ready
  );

  modport sink (
    input  valid, op, stage, slot, entry_valid, dest_start, src_start,
           range_length, value,
    output ready
  );
endinterface

interface crrm_rsp_if;
  import crrm_pkg::*;

  logic   valid;
  logic   ready;
  value_t location;
  value_t min_location;

  modport source (
    output valid, location, min_location,
    input  ready
  );

  modport sink (
    input  valid, location, min_location,
    output ready
  );
endinterface

FILE: sv/chained_range_remap_min.sv
// ----------------------------------------------------------------------------
// chained_range_remap_min
// Multi-stage range remap table with a running minimum of the results.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one item per transfer. A write item loads or clears one
//   table entry at (stage, slot). A restart item resets the running
//   minimum. A translate item sends value through all stages; in each stage
//   the lowest valid slot whose range covers the value remaps it, saturating
//   at the top of the value range.
//   rsp_o returns location and min_location for each translate item only.
//   The scan of a translate reads one table word per cycle from the single
//   read port of the table RAM, and pauses after each stage for the remap
//   pipeline to settle. One item is processed at a time; req_i.ready is
//   high only when idle. After reset the table is swept clear, one entry
//   per cycle, with req_i.ready low; the running minimum resets to all
//   ones. When rsp_o stalls, the result waits in the output register and a
//   finished translate holds until that register frees up.
// ----------------------------------------------------------------------------
module chained_range_remap_min (
  input  logic       clk_i,
  input  logic       rst_ni,
  crrm_req_if.sink   req_i,
  crrm_rsp_if.source rsp_o
);
  import crrm_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Controller
  crrm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .op_i       (req_i.op),
    .stage_i    (req_i.stage),
    .slot_i     (req_i.slot),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath
  crrm_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .wr_stage_i     (req_i.stage),
    .wr_slot_i      (req_i.slot),
    .entry_valid_i  (req_i.entry_valid),
    .dest_start_i   (req_i.dest_start),
    .src_start_i    (req_i.src_start),
    .range_length_i (req_i.range_length),
    .value_i        (req_i.value),
    .out_valid_o    (rsp_o.valid),
    .out_ready_i    (rsp_o.ready),
    .location_o     (rsp_o.location),
    .min_location_o (rsp_o.min_location)
  );

endmodule

FILE: sv/crrm_ram.sv
// ----------------------------------------------------------------------------
// crrm_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module crrm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/crrm_ctrl.sv
// ----------------------------------------------------------------------------
// crrm_ctrl
// Controller: table clearing pass, command decode, stage/slot scan sequencer.
// ----------------------------------------------------------------------------
module crrm_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [crrm_pkg::OP_W-1:0]    op_i,
  input  logic [crrm_pkg::STAGE_W-1:0] stage_i,
  input  logic [crrm_pkg::SLOT_W-1:0]  slot_i,
  input  crrm_pkg::dp_sts_t          sts_i,
  output crrm_pkg::dp_cmd_t          cmd_o
);
  import crrm_pkg::*;

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_SCAN   = 5'b00100,
    ST_GAP    = 5'b01000,
    ST_RESULT = 5'b10000
  } state_e;

  state_e                state_q, state_d;
  addr_t                 clr_cnt_q, clr_cnt_d;
  logic [STG_CNT_W-1:0]  stage_cnt_q, stage_cnt_d;
  logic [SLOT_CNT_W-1:0] slot_cnt_q, slot_cnt_d;
  logic                  gap_cnt_q, gap_cnt_d;
  logic                  accept;
  logic                  in_range;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i & in_ready_o;
  assign in_range   = (32'(stage_i) < NUM_STAGES) && (32'(slot_i) < ENTRIES_PER_STAGE);

  // Sequence the clearing pass, the scan and the result transfer
  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    stage_cnt_d = stage_cnt_q;
    slot_cnt_d  = slot_cnt_q;
    gap_cnt_d   = gap_cnt_q;
    cmd_o       = '0;
    cmd_o.clr_addr = clr_cnt_q;
    cmd_o.rd_addr  = entry_addr(addr_t'(stage_cnt_q), addr_t'(slot_cnt_q));

    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (clr_cnt_q == addr_t'(TABLE_DEPTH - 1)) begin
          state_d = ST_IDLE;
        end else begin
          clr_cnt_d = clr_cnt_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (op_i)
            OP_WRITE:     cmd_o.entry_wr = in_range;
            OP_TRANSLATE: begin
              cmd_o.load_value = 1'b1;
              stage_cnt_d      = '0;
              slot_cnt_d       = '0;
              state_d          = ST_SCAN;
            end
            OP_RESTART:   cmd_o.restart_min = 1'b1;
            default:      ;
          endcase
        end
      end
      ST_SCAN: begin
        // Issue one table read per cycle over the current stage
        cmd_o.rd_en    = 1'b1;
        cmd_o.rd_first = (slot_cnt_q == '0);
        cmd_o.rd_last  = (slot_cnt_q == SLOT_CNT_W'(ENTRIES_PER_STAGE - 1));
        if (cmd_o.rd_last) begin
          slot_cnt_d = '0;
          gap_cnt_d  = 1'b0;
          state_d    = ST_GAP;
        end else begin
          slot_cnt_d = slot_cnt_q + 1'b1;
        end
      end
      ST_GAP: begin
        // Wait for the stage result to settle before the next stage reads
        if (gap_cnt_q) begin
          if (stage_cnt_q == STG_CNT_W'(NUM_STAGES - 1)) begin
            stage_cnt_d = '0;
            state_d     = ST_RESULT;
          end else begin
            stage_cnt_d = stage_cnt_q + 1'b1;
            state_d     = ST_SCAN;
          end
        end else begin
          gap_cnt_d = 1'b1;
        end
      end
      ST_RESULT: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      stage_cnt_q <= '0;
      slot_cnt_q  <= '0;
      gap_cnt_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      stage_cnt_q <= stage_cnt_d;
      slot_cnt_q  <= slot_cnt_d;
      gap_cnt_q   <= gap_cnt_d;
    end
  end

endmodule

FILE: sv/crrm_dp.sv
// ----------------------------------------------------------------------------
// crrm_dp
// Datapath: entry table, match/offset stage, saturating remap stage,
// running minimum and result register.
// ----------------------------------------------------------------------------
module crrm_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  crrm_pkg::dp_cmd_t            cmd_i,
  output crrm_pkg::dp_sts_t            sts_o,
  input  logic [crrm_pkg::STAGE_W-1:0] wr_stage_i,
  input  logic [crrm_pkg::SLOT_W-1:0]  wr_slot_i,
  input  logic                         entry_valid_i,
  input  crrm_pkg::value_t             dest_start_i,
  input  crrm_pkg::value_t             src_start_i,
  input  crrm_pkg::value_t             range_length_i,
  input  crrm_pkg::value_t             value_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output crrm_pkg::value_t             location_o,
  output crrm_pkg::value_t             min_location_o
);
  import crrm_pkg::*;

  logic               ram_we;
  addr_t              ram_waddr;
  entry_t             ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t             rd_entry;

  logic               r_valid_q, r_first_q, r_last_q;
  logic               a_valid_q, a_first_q, a_last_q, a_hit_q;
  value_t             a_off_q, a_dest_q;

  logic [VALUE_BITS:0] diff;
  value_t              off;
  logic                hit;
  logic [VALUE_BITS:0] sum;
  value_t              sat;
  logic                base_matched;
  value_t              base_nxt;
  value_t              stage_val;

  value_t cur_q, nxt_q, min_q, loc_q, min_out_q, new_min;
  logic   matched_q, out_valid_q;

  // Table write: clearing pass or entry load
  always_comb begin
    ram_we    = cmd_i.clr_wr | cmd_i.entry_wr;
    ram_waddr = cmd_i.clr_wr ? cmd_i.clr_addr
                             : entry_addr(addr_t'(wr_stage_i), addr_t'(wr_slot_i));
    ram_wdata = '0;
    if (!cmd_i.clr_wr) begin
      ram_wdata.used = entry_valid_i;
      ram_wdata.dest = dest_start_i;
      ram_wdata.src  = src_start_i;
      ram_wdata.len  = range_length_i;
    end
  end

  crrm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (cmd_i.rd_addr),
    .rdata_o (ram_rdata)
  );

  assign rd_entry = entry_t'(ram_rdata);

  // Match test against the stage input value
  always_comb begin
    diff = {1'b0, cur_q} - {1'b0, rd_entry.src};
    off  = diff[VALUE_BITS-1:0];
    hit  = rd_entry.used & ~diff[VALUE_BITS] & (off < rd_entry.len);
  end

  // Saturating remap and first-match selection within the stage
  always_comb begin
    sum          = {1'b0, a_dest_q} + {1'b0, a_off_q};
    sat          = sum[VALUE_BITS] ? '1 : sum[VALUE_BITS-1:0];
    base_matched = a_first_q ? 1'b0 : matched_q;
    base_nxt     = a_first_q ? cur_q : nxt_q;
    stage_val    = (a_hit_q && !base_matched) ? sat : base_nxt;
    new_min      = (cur_q < min_q) ? cur_q : min_q;
  end

  // Pipeline tags and control flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_valid_q   <= 1'b0;
      a_valid_q   <= 1'b0;
      matched_q   <= 1'b0;
      out_valid_q <= 1'b0;
      min_q       <= '1;
    end else begin
      r_valid_q <= cmd_i.rd_en;
      a_valid_q <= r_valid_q;
      if (a_valid_q) begin
        matched_q <= base_matched | a_hit_q;
      end
      if (cmd_i.restart_min) begin
        min_q <= '1;
      end else if (cmd_i.load_out) begin
        min_q <= new_min;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    r_first_q <= cmd_i.rd_first;
    r_last_q  <= cmd_i.rd_last;
    a_first_q <= r_first_q;
    a_last_q  <= r_last_q;
    a_hit_q   <= hit;
    a_off_q   <= off;
    a_dest_q  <= rd_entry.dest;
    if (a_valid_q) begin
      nxt_q <= stage_val;
    end
    if (cmd_i.load_value) begin
      cur_q <= value_i;
    end else if (a_valid_q && a_last_q) begin
      cur_q <= stage_val;
    end
    if (cmd_i.load_out) begin
      loc_q     <= cur_q;
      min_out_q <= new_min;
    end
  end

  assign sts_o.out_free = ~out_valid_q | out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign location_o     = loc_q;
  assign min_location_o = min_out_q;

endmodule

FILE: bench/tb_chained_range_remap_min.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_chained_range_remap_min
// Self-checking bench for the chained range remap block. It drives table
// writes, translates, minimum restarts and the ignored op code through the
// request channel in random bursts, mirrors the remap table in a local
// model, and compares every returned location and running minimum, field by
// field, in transfer order. The response side stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb_chained_range_remap_min;
  import crrm_pkg::*;

  // Ignored fourth op code
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam value_t VALUE_MAX         = '1;
  localparam int     TRANSLATE_LATENCY = NUM_STAGES * (ENTRIES_PER_STAGE + 2) + 2;
  localparam int     NARROW_SPAN       = 4096;
  localparam int     RANDOM_ITEMS      = 1145;

  // Worst case: every item a translate plus the longest response
  // stall and sender gap, about 5.2 ms; allow roughly 6x.
  localparam int     RUN_LIMIT_NS      = 30_000_000;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [STAGE_W-1:0] stage;
    logic [SLOT_W-1:0]  slot;
    logic               entry_valid;
    value_t             dest_start;
    value_t             src_start;
    value_t             range_length;
    value_t             value;
  } remap_req_t;

  typedef struct packed {
    value_t location;
    value_t min_location;
  } loc_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  crrm_req_if req_if ();
  crrm_rsp_if rsp_if ();

  chained_range_remap_min u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // Mirror of the remap table and the running minimum
  value_t      tbl_dest [TABLE_DEPTH];
  value_t      tbl_src  [TABLE_DEPTH];
  value_t      tbl_len  [TABLE_DEPTH];
  bit          tbl_used [TABLE_DEPTH];
  value_t      lowest_loc = VALUE_MAX;
  loc_result_t pending_locs[$];
  int          err_count  = 0;
  int          burst_left = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Walk a value through every stage; lowest matching slot wins per stage
  function automatic value_t remap_through_stages(value_t start);
    value_t v;
    value_t off;
    int     idx;
    bit     hit;
    v = start;
    for (int st = 0; st < NUM_STAGES; st++) begin
      hit = 1'b0;
      for (int sl = 0; sl < ENTRIES_PER_STAGE && !hit; sl++) begin
        idx = st * ENTRIES_PER_STAGE + sl;
        if (tbl_used[idx] && v >= tbl_src[idx]) begin
          off = v - tbl_src[idx];
          if (off < tbl_len[idx]) begin
            hit = 1'b1;
            // saturate instead of wrapping past the top of the range
            v = (off > VALUE_MAX - tbl_dest[idx]) ? VALUE_MAX : tbl_dest[idx] + off;
          end
        end
      end
    end
    return v;
  endfunction

  // Update the mirror for one accepted item and queue its expected result
  function automatic void predict_remap(remap_req_t it);
    int          idx;
    loc_result_t res;
    case (it.op)
      OP_WRITE: begin
        if (int'(it.stage) < NUM_STAGES && int'(it.slot) < ENTRIES_PER_STAGE) begin
          idx = int'(it.stage) * ENTRIES_PER_STAGE + int'(it.slot);
          tbl_used[idx] = it.entry_valid;
          tbl_dest[idx] = it.dest_start;
          tbl_src[idx]  = it.src_start;
          tbl_len[idx]  = it.range_length;
        end
      end
      OP_TRANSLATE: begin
        res.location = remap_through_stages(it.value);
        if (res.location < lowest_loc) lowest_loc = res.location;
        res.min_location = lowest_loc;
        pending_locs = {pending_locs, res};
      end
      OP_RESTART: lowest_loc = VALUE_MAX;
      default: ;
    endcase
  endfunction

  function automatic value_t rand_word();
    return value_t'({$urandom(), $urandom()});
  endfunction

  // Fully random item; every field and op code possible
  function automatic remap_req_t random_noise();
    remap_req_t it;
    it.op           = OP_W'($urandom_range(0, 3));
    it.stage        = STAGE_W'($urandom());
    it.slot         = SLOT_W'($urandom());
    it.entry_valid  = 1'($urandom_range(0, 1));
    it.dest_start   = rand_word();
    it.src_start    = rand_word();
    it.range_length = rand_word();
    it.value        = rand_word();
    return it;
  endfunction

  function automatic remap_req_t mk_write(int st, int sl, bit in_use, value_t dest,
                                          value_t src, value_t len);
    remap_req_t it;
    it              = random_noise();
    it.op           = OP_WRITE;
    it.stage        = STAGE_W'(st);
    it.slot         = SLOT_W'(sl);
    it.entry_valid  = in_use;
    it.dest_start   = dest;
    it.src_start    = src;
    it.range_length = len;
    return it;
  endfunction

  function automatic remap_req_t mk_xlate(value_t v);
    remap_req_t it;
    it       = random_noise();
    it.op    = OP_TRANSLATE;
    it.value = v;
    return it;
  endfunction

  // Entry write; narrow mode packs ranges into a small window so stages chain
  function automatic remap_req_t random_entry_write(bit narrow);
    remap_req_t it;
    it             = random_noise();
    it.op          = OP_WRITE;
    it.entry_valid = ($urandom_range(0, 6) != 0);
    if (narrow) begin
      it.src_start    = value_t'($urandom_range(0, NARROW_SPAN - 1));
      it.range_length = ($urandom_range(0, 9) == 0) ? '0
                                                     : value_t'($urandom_range(1, 512));
      it.dest_start   = ($urandom_range(0, 9) == 0)
                        ? VALUE_MAX - value_t'($urandom_range(0, 300))
                        : value_t'($urandom_range(0, NARROW_SPAN - 1));
    end else if ($urandom_range(0, 1) == 0) begin
      it.range_length = value_t'($urandom_range(0, 1 << 20));
    end
    return it;
  endfunction

  // Translate aimed mostly at stored ranges, else at the window or the edges
  function automatic remap_req_t random_translate(bit narrow);
    remap_req_t it;
    int         pick;
    int         idx;
    it   = mk_xlate(rand_word());
    pick = $urandom_range(0, 99);
    idx  = $urandom_range(0, TABLE_DEPTH - 1);
    if (pick < 55 && tbl_used[idx] && tbl_len[idx] != 0) begin
      it.value = tbl_src[idx] + rand_word() % tbl_len[idx];
    end else if (pick < 80) begin
      if (narrow) it.value = value_t'($urandom_range(0, NARROW_SPAN - 1));
    end else begin
      case ($urandom_range(0, 3))
        0: it.value = '0;
        1: it.value = VALUE_MAX;
        2: it.value = VALUE_MAX - value_t'($urandom_range(0, 15));
        default: it.value = value_t'($urandom_range(0, 15));
      endcase
    end
    return it;
  endfunction

  // Present one item and hold it until the transfer
  task automatic send_item(remap_req_t it);
    req_if.valid        <= 1'b1;
    req_if.op           <= it.op;
    req_if.stage        <= it.stage;
    req_if.slot         <= it.slot;
    req_if.entry_valid  <= it.entry_valid;
    req_if.dest_start   <= it.dest_start;
    req_if.src_start    <= it.src_start;
    req_if.range_length <= it.range_length;
    req_if.value        <= it.value;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    predict_remap(it);
  endtask

  // Burst pacing: random burst lengths, random gaps, occasional long runs
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 12);
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(0, 24);
    end
  endtask

  // Drop valid and hold until every queued result has come back
  task automatic wait_results_drained();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_locs.size() != 0);
  endtask

  task automatic test_empty_table();
    send_item(mk_xlate('0));
    pace();
    send_item(mk_xlate(VALUE_MAX));
    pace();
  endtask

  task automatic test_remap_edges();
    // zero length never matches
    send_item(mk_write(0, 0, 1'b1, 7, 100, 0));
    send_item(mk_xlate(100));
    pace();
    // range running past the top of the value range
    send_item(mk_write(NUM_STAGES - 1, ENTRIES_PER_STAGE - 1, 1'b1, 16, VALUE_MAX - 9,
                       VALUE_MAX));
    send_item(mk_xlate(VALUE_MAX));
    pace();
    // destination overflow saturates; exact top does not
    send_item(mk_write(2, 3, 1'b1, VALUE_MAX - 5, 0, 1000));
    send_item(mk_xlate(4));
    send_item(mk_xlate(5));
    send_item(mk_xlate(20));
    pace();
    // last covered value matches, one past it does not
    send_item(mk_write(3, 0, 1'b1, 0, 5000, 10));
    send_item(mk_xlate(5009));
    send_item(mk_xlate(5010));
    pace();
  endtask

  task automatic test_priority_and_chain();
    // overlapping entries: lower slot wins
    send_item(mk_write(4, 10, 1'b1, 3000, 2000, 100));
    send_item(mk_write(4, 2, 1'b1, 9000, 2050, 100));
    send_item(mk_xlate(2060));
    send_item(mk_xlate(2010));
    pace();
    // chain a later stage onto the earlier result
    send_item(mk_write(5, ENTRIES_PER_STAGE - 1, 1'b1, 123, 9000, 100));
    send_item(mk_xlate(2060));
    // cleared entry keeps its fields but no longer matches
    send_item(mk_write(4, 2, 1'b0, 9000, 2050, 100));
    send_item(mk_xlate(2060));
    pace();
  endtask

  task automatic test_clear_and_restart();
    remap_req_t it;
    it    = random_noise();
    it.op = OP_RESTART;
    send_item(it);
    send_item(mk_xlate(rand_word()));
    // ignored op code must leave the minimum alone
    it    = mk_xlate(0);
    it.op = OP_UNUSED;
    send_item(it);
    send_item(mk_xlate(rand_word()));
    wait_results_drained();
    it    = random_noise();
    it.op = OP_RESTART;
    send_item(it);
    send_item(mk_xlate(VALUE_MAX));
    pace();
  endtask

  task automatic test_random_traffic();
    remap_req_t it;
    int         counted;
    int         span_left;
    int         pick;
    bit         narrow;
    counted   = 0;
    span_left = 0;
    narrow    = 1'b1;
    while (counted < RANDOM_ITEMS) begin
      // switch between a dense small window and full-width values
      if (span_left == 0) begin
        narrow    = ($urandom_range(0, 9) < 7);
        span_left = $urandom_range(20, 60);
      end
      span_left--;
      pick = $urandom_range(0, 99);
      if (pick < 44) begin
        it = random_entry_write(narrow);
      end else if (pick < 88) begin
        it = random_translate(narrow);
      end else if (pick < 96) begin
        it    = random_noise();
        it.op = (pick < 92) ? OP_RESTART : OP_UNUSED;
      end else begin
        it = random_noise();
      end
      send_item(it);
      if (it.op != OP_UNUSED) counted++;
      pace();
    end
  endtask

  // Check each result transfer; stall the response side on a rotating pattern
  always @(posedge clk_i) begin : rsp_check
    loc_result_t  want;
    bit [7:0]     phase;
    int unsigned  stall_mode;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pending_locs.size() == 0) begin
        $error("location: expected no result, got %0h", rsp_if.location);
        err_count++;
      end else begin
        want = pending_locs.pop_front();
        if (rsp_if.location !== want.location) begin
          $error("location: expected %0h, got %0h", want.location, rsp_if.location);
          err_count++;
        end
        if (rsp_if.min_location !== want.min_location) begin
          $error("min_location: expected %0h, got %0h", want.min_location,
                 rsp_if.min_location);
          err_count++;
        end
      end
    end
    phase++;
    if (phase == 0) stall_mode = $urandom_range(0, 2);
    case (stall_mode)
      0:       rsp_if.ready <= 1'b1;
      1:       rsp_if.ready <= 1'($urandom_range(0, 1));
      default: rsp_if.ready <= (phase[1:0] == 2'b11);
    endcase
  end

  initial begin
    rst_ni              <= 1'b0;
    req_if.valid        <= 1'b0;
    req_if.op           <= OP_WRITE;
    req_if.stage        <= '0;
    req_if.slot         <= '0;
    req_if.entry_valid  <= 1'b0;
    req_if.dest_start   <= '0;
    req_if.src_start    <= '0;
    req_if.range_length <= '0;
    req_if.value        <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_table();
    test_remap_edges();
    test_priority_and_chain();
    test_clear_and_restart();
    test_random_traffic();

    // drain, then watch for stray results before the verdict
    wait_results_drained();
    repeat (TRANSLATE_LATENCY + 64) @(posedge clk_i);
    if (err_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
